>>> hdl/sdol_pkg.sv
// ----------------------------------------------------------------------------
// sdol_pkg
// Shared types and codes for the sorted draw-order list and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package sdol_pkg;

   // Request modes
   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_REMOVE = 2'd1;
   localparam logic [1:0] MODE_CHANGE = 2'd2;
   localparam logic [1:0] MODE_READ   = 2'd3;

   // Response status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
   localparam logic [1:0] STATUS_BAD_POS   = 2'd3;

   // Cell operations broadcast along the chain
   localparam logic [1:0] CELL_HOLD   = 2'd0;
   localparam logic [1:0] CELL_FIND   = 2'd1;
   localparam logic [1:0] CELL_REMOVE = 2'd2;
   localparam logic [1:0] CELL_INSERT = 2'd3;

   // Command broadcast to every cell
   typedef struct packed {
      logic [1:0]         op;
      logic [15:0]        id;
      logic signed [31:0] order;
   } cell_cmd_type;

   // Contents one cell hands to its neighbors
   typedef struct packed {
      logic               valid;
      logic [15:0]        id;
      logic signed [31:0] order;
   } cell_link_type;

endpackage

`default_nettype wire

>>> hdl/sorted_draw_order_list.sv
// ----------------------------------------------------------------------------
// sorted_draw_order_list
// Object table kept sorted by signed draw order in a chain of entry cells.
// ----------------------------------------------------------------------------
// Entries live in a row of CAPACITY cells, smallest order at cell 0; an insert
// lands in front of the first entry whose order is greater or equal, and every
// cell decides on each step whether to keep, take the new entry or take its
// neighbor. An insert goes through the insert step (skipped if the table is
// full) and a read through the read step. Removal takes two chain steps (match
// flags, then shift toward the head), change order adds one insert step (none
// if the identifier is absent), and every response passes through a final
// output step, which waits while the previous response is still stalled. One
// request is in flight at a time; the next one is accepted once the response
// is loaded, even if it has not yet been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_draw_order_list #(
   parameter int CAPACITY = 64
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_stall,
   input  wire  [1:0]         req_mode,
   input  wire  [15:0]        req_object_id,
   input  wire  signed [31:0] req_draw_order,
   input  wire  [5:0]         req_position,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output logic [1:0]         rsp_status,
   output logic [15:0]        rsp_read_id,
   output logic signed [31:0] rsp_read_order,
   output logic [6:0]         rsp_entry_count
);
   import sdol_pkg::*;

   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > 6) ? CW : 6;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_FIND   = 3'd1;
   localparam logic [2:0] ST_REMOVE = 3'd2;
   localparam logic [2:0] ST_INSERT = 3'd3;
   localparam logic [2:0] ST_READ   = 3'd4;
   localparam logic [2:0] ST_DONE   = 3'd5;

   logic [2:0]         state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [1:0]         mode_ff, mode_in;
   logic [15:0]        id_ff, id_in;
   logic signed [31:0] order_ff, order_in;
   logic [5:0]         pos_ff, pos_in;
   logic [1:0]         status_ff, status_in;
   logic [15:0]        rid_ff, rid_in;
   logic signed [31:0] rord_ff, rord_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_status_ff;
   logic [15:0]        rsp_id_ff;
   logic signed [31:0] rsp_order_ff;
   logic [6:0]         rsp_count_ff;

   cell_cmd_type       cmd;
   cell_link_type      cell_link [CAPACITY];
   logic               cell_lt   [CAPACITY];
   logic               cell_seen [CAPACITY];
   logic               found;
   logic               req_beat;
   logic               rsp_free;
   logic [CMPW-1:0]    pos_ext;
   logic [CMPW-1:0]    count_ext;
   logic [15:0]        sel_id;
   logic signed [31:0] sel_order;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_beat  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign found     = cell_seen[CAPACITY-1];
   assign pos_ext   = CMPW'(pos_ff);
   assign count_ext = CMPW'(count_ff);

   // Command broadcast to the chain
   always_comb begin
      cmd.id    = id_ff;
      cmd.order = order_ff;
      case (state_ff)
         ST_FIND:   cmd.op = CELL_FIND;
         ST_REMOVE: cmd.op = CELL_REMOVE;
         ST_INSERT: cmd.op = CELL_INSERT;
         default:   cmd.op = CELL_HOLD;
      endcase
   end

   // Cell chain
   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         cell_link_type prev_link;
         cell_link_type next_link;
         logic          prev_lt;
         logic          seen_in;
         if (gi == 0) begin : g_head
            assign prev_link = '{valid: 1'b1, id: 16'd0, order: 32'sd0};
            assign prev_lt   = 1'b1;
            assign seen_in   = 1'b0;
         end else begin : g_body
            assign prev_link = cell_link[gi-1];
            assign prev_lt   = cell_lt[gi-1];
            assign seen_in   = cell_seen[gi-1];
         end
         if (gi == CAPACITY - 1) begin : g_tail
            assign next_link = '{valid: 1'b0, id: 16'd0, order: 32'sd0};
         end else begin : g_mid
            assign next_link = cell_link[gi+1];
         end
         sdol_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .cmd       (cmd),
            .prev_link (prev_link),
            .prev_lt   (prev_lt),
            .next_link (next_link),
            .seen_in   (seen_in),
            .link      (cell_link[gi]),
            .lt        (cell_lt[gi]),
            .seen_out  (cell_seen[gi])
         );
      end
   endgenerate

   // Position select: AND-OR over the cell outputs
   always_comb begin
      sel_id    = '0;
      sel_order = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (pos_ext == CMPW'(i)) begin
            sel_id    = sel_id | cell_link[i].id;
            sel_order = sel_order | cell_link[i].order;
         end
      end
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      mode_in      = mode_ff;
      id_in        = id_ff;
      order_in     = order_ff;
      pos_in       = pos_ff;
      status_in    = status_ff;
      rid_in       = rid_ff;
      rord_in      = rord_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               mode_in   = req_mode;
               id_in     = req_object_id;
               order_in  = req_draw_order;
               pos_in    = req_position;
               status_in = STATUS_OK;
               rid_in    = '0;
               rord_in   = '0;
               case (req_mode)
                  MODE_INSERT: begin
                     if (count_ff == CW'(CAPACITY)) begin
                        status_in = STATUS_FULL;
                        state_in  = ST_DONE;
                     end else begin
                        state_in = ST_INSERT;
                     end
                  end
                  MODE_REMOVE: state_in = ST_FIND;
                  MODE_CHANGE: state_in = ST_FIND;
                  default:     state_in = ST_READ;
               endcase
            end
         end
         ST_FIND: begin
            state_in = ST_REMOVE;
         end
         ST_REMOVE: begin
            if (found) begin
               count_in = count_ff - CW'(1);
               state_in = (mode_ff == MODE_CHANGE) ? ST_INSERT : ST_DONE;
            end else begin
               status_in = STATUS_NOT_FOUND;
               state_in  = ST_DONE;
            end
         end
         ST_INSERT: begin
            count_in = count_ff + CW'(1);
            state_in = ST_DONE;
         end
         ST_READ: begin
            if (pos_ext < count_ext) begin
               rid_in  = sel_id;
               rord_in = sel_order;
            end else begin
               status_in = STATUS_BAD_POS;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request and working payload
   always_ff @(posedge clock) begin
      mode_ff   <= mode_in;
      id_ff     <= id_in;
      order_ff  <= order_in;
      pos_ff    <= pos_in;
      status_ff <= status_in;
      rid_ff    <= rid_in;
      rord_ff   <= rord_in;
   end

   // Response register, loaded on the final step
   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE && rsp_free) begin
         rsp_status_ff <= status_ff;
         rsp_id_ff     <= rid_ff;
         rsp_order_ff  <= rord_ff;
         rsp_count_ff  <= 7'(count_ff);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_read_id     = rsp_id_ff;
   assign rsp_read_order  = rsp_order_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule

`default_nettype wire

>>> hdl/sdol_cell.sv
// ----------------------------------------------------------------------------
// sdol_cell
// One slot of the sorted list: holds an entry, shifts toward the tail on
// insert and toward the head on remove, based on its neighbors' flags.
// ----------------------------------------------------------------------------
`default_nettype none

module sdol_cell (
   input  wire                          clock,
   input  wire                          reset,
   input  wire sdol_pkg::cell_cmd_type  cmd,
   input  wire sdol_pkg::cell_link_type prev_link,
   input  wire                          prev_lt,
   input  wire sdol_pkg::cell_link_type next_link,
   input  wire                          seen_in,
   output sdol_pkg::cell_link_type      link,
   output logic                         lt,
   output logic                         seen_out
);
   import sdol_pkg::*;

   logic               valid_ff, valid_in;
   logic               match_ff, match_in;
   logic [15:0]        id_ff, id_in;
   logic signed [31:0] order_ff, order_in;

   // Local flags: entry sorts before the new one; first match at or above here
   assign lt       = valid_ff && (order_ff < cmd.order);
   assign seen_out = seen_in | match_ff;

   assign link.valid = valid_ff;
   assign link.id    = id_ff;
   assign link.order = order_ff;

   // Next-state selection
   always_comb begin
      valid_in = valid_ff;
      id_in    = id_ff;
      order_in = order_ff;
      match_in = match_ff;
      case (cmd.op)
         CELL_FIND: begin
            match_in = valid_ff && (id_ff == cmd.id);
         end
         CELL_REMOVE: begin
            match_in = 1'b0;
            if (seen_out) begin
               valid_in = next_link.valid;
               id_in    = next_link.id;
               order_in = next_link.order;
            end
         end
         CELL_INSERT: begin
            if (!lt) begin
               valid_in = valid_ff | prev_link.valid;
               if (prev_lt) begin
                  id_in    = cmd.id;
                  order_in = cmd.order;
               end else begin
                  id_in    = prev_link.id;
                  order_in = prev_link.order;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         match_ff <= match_in;
      end
   end

   // Entry payload
   always_ff @(posedge clock) begin
      id_ff    <= id_in;
      order_ff <= order_in;
   end

endmodule

`default_nettype wire

>>> tb/sdol_checker.sv
// ----------------------------------------------------------------------------
// sdol_checker
// Watches both channels of the sorted draw-order list and checks every
// response beat against a local copy of the sorted table.
// ----------------------------------------------------------------------------
// Each accepted request beat is applied to a shadow table (ids and signed
// orders, smallest order first), and the response it should produce is queued.
// Each accepted response beat is compared field by field with the oldest
// queued response. The failure count, the number of responses still owed and
// the shadow entry count are handed to the testbench top.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sdol_checker #(
   parameter int CAPACITY = 64
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   input  wire                req_stall,
   input  wire  [1:0]         req_mode,
   input  wire  [15:0]        req_object_id,
   input  wire  signed [31:0] req_draw_order,
   input  wire  [5:0]         req_position,
   input  wire                rsp_valid,
   input  wire                rsp_stall,
   input  wire  [1:0]         rsp_status,
   input  wire  [15:0]        rsp_read_id,
   input  wire  signed [31:0] rsp_read_order,
   input  wire  [6:0]         rsp_entry_count,
   output int                 fail_count,
   output int                 pending,
   output int                 table_count
);
   import sdol_pkg::*;

   typedef struct packed {
      logic [1:0]         status;
      logic [15:0]        read_id;
      logic signed [31:0] read_order;
      logic [6:0]         entry_count;
   } list_rsp_type;

   // Shadow table, valid below n_entries only
   logic signed [31:0] ord_tbl [CAPACITY];
   logic [15:0]        id_tbl  [CAPACITY];
   int                 n_entries;

   list_rsp_type awaited_rsps [$];
   list_rsp_type want;
   list_rsp_type owed;
   int           rsp_beats;

   initial begin
      fail_count  = 0;
      pending     = 0;
      table_count = 0;
      n_entries   = 0;
      rsp_beats   = 0;
   end

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      fail_count++;
   endtask

   // Place an entry in front of the first one with order >= the new order
   function automatic void insert_in_order(input logic [15:0] id,
                                           input logic signed [31:0] ord);
      int slot;
      int i;
      slot = 0;
      while (slot < n_entries && ord_tbl[slot] < ord) slot++;
      for (i = n_entries; i > slot; i--) begin
         id_tbl[i]  = id_tbl[i - 1];
         ord_tbl[i] = ord_tbl[i - 1];
      end
      id_tbl[slot]  = id;
      ord_tbl[slot] = ord;
      n_entries++;
   endfunction

   // Apply one request to the shadow table and return the response it owes
   function automatic list_rsp_type apply_list_op(input logic [1:0] mode,
                                                  input logic [15:0] id,
                                                  input logic signed [31:0] ord,
                                                  input logic [5:0] pos);
      list_rsp_type r;
      int hit;
      int i;
      r = '0;
      r.status = STATUS_OK;
      case (mode)
         MODE_INSERT: begin
            if (n_entries >= CAPACITY) r.status = STATUS_FULL;
            else insert_in_order(id, ord);
         end
         MODE_REMOVE, MODE_CHANGE: begin
            // first match in table order
            hit = -1;
            for (i = 0; i < n_entries; i++)
               if (hit < 0 && id_tbl[i] == id) hit = i;
            if (hit < 0) begin
               r.status = STATUS_NOT_FOUND;
            end else begin
               for (i = hit; i < n_entries - 1; i++) begin
                  id_tbl[i]  = id_tbl[i + 1];
                  ord_tbl[i] = ord_tbl[i + 1];
               end
               n_entries--;
               if (mode == MODE_CHANGE) insert_in_order(id, ord);
            end
         end
         default: begin
            // read at position
            if (pos >= n_entries) begin
               r.status = STATUS_BAD_POS;
            end else begin
               r.read_id    = id_tbl[pos];
               r.read_order = ord_tbl[pos];
            end
         end
      endcase
      r.entry_count = 7'(n_entries);
      return r;
   endfunction

   // Response beat first: a request accepted on the same edge is the next one
   always @(posedge clock) begin
      if (reset) begin
         awaited_rsps.delete();
         n_entries = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_rsps.size() == 0) begin
               report_mismatch($sformatf("response beat %0d with no request owed",
                                         rsp_beats));
            end else begin
               want = awaited_rsps.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("beat %0d status %0d, expected %0d",
                                            rsp_beats, rsp_status, want.status));
               if (rsp_read_id !== want.read_id)
                  report_mismatch($sformatf("beat %0d read_id %h, expected %h",
                                            rsp_beats, rsp_read_id, want.read_id));
               if (rsp_read_order !== want.read_order)
                  report_mismatch($sformatf("beat %0d read_order %0d, expected %0d",
                                            rsp_beats, rsp_read_order, want.read_order));
               if (rsp_entry_count !== want.entry_count)
                  report_mismatch($sformatf("beat %0d entry_count %0d, expected %0d",
                                            rsp_beats, rsp_entry_count, want.entry_count));
            end
            rsp_beats++;
         end
         if (req_valid && !req_stall) begin
            owed = apply_list_op(req_mode, req_object_id, req_draw_order, req_position);
            awaited_rsps = {awaited_rsps, owed};
         end
      end
      pending     = awaited_rsps.size();
      table_count = n_entries;
   end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the sorted draw-order list.
// ----------------------------------------------------------------------------
// A short directed sequence covers the empty table, extreme orders, equal
// orders, duplicate ids and reads past the count. Random phases then fill the
// table to full, mix all operations and drain it again, with bursty request
// traffic and a response side that stalls in changing patterns. The checker
// beside the block does all prediction and comparison.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
   import sdol_pkg::*;

   localparam int CAPACITY     = 64;
   localparam int RANDOM_ITEMS = 450;
   localparam int QUIET_LIMIT  = 500;
   localparam int DRAIN_CYCLES = 20;

   typedef enum {PH_FILL, PH_MIX, PH_DRAIN} phase_kind_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_mode;
   logic [15:0]        req_object_id;
   logic signed [31:0] req_draw_order;
   logic [5:0]         req_position;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [1:0]         rsp_status;
   logic [15:0]        rsp_read_id;
   logic signed [31:0] rsp_read_order;
   logic [6:0]         rsp_entry_count;

   int fail_count;
   int pending;
   int table_count;

   logic [15:0] id_pool [16];
   int          burst_left;
   int          quiet_cycles;

   sorted_draw_order_list #(.CAPACITY(CAPACITY)) uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_object_id   (req_object_id),
      .req_draw_order  (req_draw_order),
      .req_position    (req_position),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_read_id     (rsp_read_id),
      .rsp_read_order  (rsp_read_order),
      .rsp_entry_count (rsp_entry_count)
   );

   sdol_checker #(.CAPACITY(CAPACITY)) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_object_id   (req_object_id),
      .req_draw_order  (req_draw_order),
      .req_position    (req_position),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_read_id     (rsp_read_id),
      .rsp_read_order  (rsp_read_order),
      .rsp_entry_count (rsp_entry_count),
      .fail_count      (fail_count),
      .pending         (pending),
      .table_count     (table_count)
   );

   always #1 clock = ~clock;

   // Response side stall: a style is held for a while, then another is picked
   int stall_style;
   int style_left;
   int run_left;
   int tick;
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall   <= 1'b0;
         stall_style = 0;
         style_left  = 0;
         run_left    = 0;
         tick        = 0;
      end else begin
         if (style_left == 0) begin
            stall_style = $urandom_range(0, 3);
            style_left  = $urandom_range(20, 80);
         end
         style_left--;
         tick++;
         case (stall_style)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 2) == 0);
            2: begin
               // long stall runs
               if (run_left == 0 && $urandom_range(0, 7) == 0)
                  run_left = $urandom_range(1, 10);
               rsp_stall <= (run_left > 0);
               if (run_left > 0) run_left--;
            end
            default: rsp_stall <= (tick % 3 == 0);
         endcase
      end
   end

   // Watchdog: too long without any beat on either channel
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // Present one request beat from a falling edge and hold it until taken
   task automatic send_item(input logic [1:0] mode, input logic [15:0] id,
                            input logic signed [31:0] ord, input logic [5:0] pos);
      req_valid      <= 1'b1;
      req_mode       <= mode;
      req_object_id  <= id;
      req_draw_order <= ord;
      req_position   <= pos;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // Burst pacing: keep valid up inside a burst, drop it for a gap between
   task automatic pace_sender();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                   : $urandom_range(0, 10);
      end
   endtask

   // Hold off until every owed response has come back
   task automatic wait_all_returned();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
   endtask

   // Orders: mostly a narrow band to force ties, plus extremes and full range
   function automatic logic signed [31:0] pick_order();
      int r;
      logic signed [15:0] half;
      r = $urandom_range(0, 99);
      half = 16'($urandom);
      if (r < 40) return $signed($urandom_range(0, 8)) - 4;
      if (r < 70) return $urandom;
      if (r < 85) begin
         case ($urandom_range(0, 5))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return -1;
            3: return 0;
            4: return 32'sh8000_0001;
            default: return 32'sh7FFF_FFFE;
         endcase
      end
      return 32'(half);
   endfunction

   // Positions: mostly live entries, some at the count, some anywhere
   function automatic logic [5:0] pick_position();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60 && table_count > 0) return 6'($urandom_range(0, table_count - 1));
      if (r < 75) return 6'((table_count < CAPACITY) ? table_count : CAPACITY - 1);
      return 6'($urandom_range(0, 63));
   endfunction

   task automatic random_op(input phase_kind_type ph);
      int r;
      logic [1:0] mode;
      logic [15:0] id;
      r = $urandom_range(0, 99);
      case (ph)
         PH_FILL:  mode = (r < 70) ? MODE_INSERT : (r < 78) ? MODE_REMOVE :
                          (r < 88) ? MODE_CHANGE : MODE_READ;
         PH_DRAIN: mode = (r < 8)  ? MODE_INSERT : (r < 70) ? MODE_REMOVE :
                          (r < 80) ? MODE_CHANGE : MODE_READ;
         default:  mode = (r < 25) ? MODE_INSERT : (r < 50) ? MODE_REMOVE :
                          (r < 75) ? MODE_CHANGE : MODE_READ;
      endcase
      // inserts stay in the pool so the table can drain; others sometimes miss
      id = id_pool[$urandom_range(0, 15)];
      if (mode != MODE_INSERT && $urandom_range(0, 6) == 0) id = 16'($urandom);
      send_item(mode, id, pick_order(), pick_position());
   endtask

   initial begin
      int             random_sent;
      int             step;
      int             phase_items;
      int             tail;
      bit             phase_done;
      phase_kind_type ph;

      reset          = 1'b1;
      req_valid      = 1'b0;
      req_mode       = MODE_INSERT;
      req_object_id  = '0;
      req_draw_order = '0;
      req_position   = '0;
      rsp_stall      = 1'b0;
      burst_left     = 0;

      id_pool[0] = 16'h0000;
      id_pool[1] = 16'hFFFF;
      for (int i = 2; i < 16; i++) id_pool[i] = 16'($urandom);

      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // Directed: empty table, extremes, ties, duplicates, reads past count
      send_item(MODE_READ,   16'h0000, 0, 6'd0);            pace_sender();
      send_item(MODE_REMOVE, 16'h1234, 0, 6'd0);            pace_sender();
      send_item(MODE_CHANGE, 16'h0005, 7, 6'd0);            pace_sender();
      send_item(MODE_INSERT, 16'hFFFF, 32'sh7FFF_FFFF, 6'd0); pace_sender();
      send_item(MODE_INSERT, 16'h0000, 32'sh8000_0000, 6'd0); pace_sender();
      send_item(MODE_INSERT, 16'h00A5, 0, 6'd0);            pace_sender();
      send_item(MODE_INSERT, 16'h00A5, 0, 6'd0);            pace_sender();
      send_item(MODE_INSERT, 16'h5A5A, 0, 6'd63);           pace_sender();
      send_item(MODE_READ,   16'hFFFF, -1, 6'd0);           pace_sender();
      send_item(MODE_READ,   16'h0000, 0, 6'd1);            pace_sender();
      send_item(MODE_READ,   16'h0000, 0, 6'd4);            pace_sender();
      send_item(MODE_READ,   16'h0000, 0, 6'd5);            pace_sender();
      send_item(MODE_READ,   16'h0000, 0, 6'd63);           pace_sender();
      send_item(MODE_CHANGE, 16'h00A5, -1, 6'd0);           pace_sender();
      send_item(MODE_READ,   16'h0000, 0, 6'd1);            pace_sender();
      send_item(MODE_REMOVE, 16'h00A5, 0, 6'd0);            pace_sender();
      send_item(MODE_CHANGE, 16'hFFFF, 32'sh8000_0000, 6'd0); pace_sender();
      send_item(MODE_REMOVE, 16'h0000, 0, 6'd0);            pace_sender();
      send_item(MODE_READ,   16'h0000, 0, 6'd0);            pace_sender();
      send_item(MODE_REMOVE, 16'hBEEF, 0, 6'd0);            pace_sender();
      send_item(MODE_CHANGE, 16'h5A5A, 32'sh7FFF_FFFF, 6'd0); pace_sender();
      send_item(MODE_READ,   16'h0000, 0, 6'd2);
      wait_all_returned();

      // Random phases: fill to full, mix, drain toward empty, mix, repeat
      random_sent = 0;
      step = 0;
      while (random_sent < RANDOM_ITEMS) begin
         case (step % 4)
            0:       ph = PH_FILL;
            2:       ph = PH_DRAIN;
            default: ph = PH_MIX;
         endcase
         phase_items = 0;
         tail = 0;
         phase_done = 1'b0;
         while (!phase_done && random_sent < RANDOM_ITEMS) begin
            random_op(ph);
            random_sent++;
            phase_items++;
            case (ph)
               PH_FILL: begin
                  if (table_count >= CAPACITY) tail++;
                  phase_done = (tail >= 12) || (phase_items >= 200);
               end
               PH_DRAIN: begin
                  if (table_count == 0) tail++;
                  phase_done = (tail >= 6) || (phase_items >= 180);
               end
               default: phase_done = (phase_items >= 60);
            endcase
            if (phase_done || random_sent >= RANDOM_ITEMS) wait_all_returned();
            else pace_sender();
         end
         step++;
      end

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
